// ----- hw/rtl/vds_pkg.sv -----
// shared types and constants of the velocity difference smoother
package vds_pkg;

    // field widths
    localparam int POS_W    = 24;
    localparam int SPD_W    = 32;
    localparam int RATE_W   = 8;
    localparam int CFG_W    = 5;
    localparam int DIFF_W   = POS_W + 1;
    localparam int PROD_W   = DIFF_W + RATE_W;
    localparam int DIV_STEP = 4;

    // configuration port
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 8;

    localparam logic [CFG_IDX_W-1:0] CFG_RATE     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_INTERVAL = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_AVG      = 2'd2;

    localparam logic [RATE_W-1:0] RATE_RST     = 8'd25;
    localparam logic [CFG_W-1:0]  INTERVAL_RST = 5'd1;
    localparam logic [CFG_W-1:0]  AVG_RST      = 5'd5;

    typedef logic signed [POS_W-1:0] pos_t;
    typedef logic signed [SPD_W-1:0] spd_t;

    typedef struct packed {
        pos_t pos_x;
        pos_t pos_y;
        pos_t pos_z;
    } sample_t;

    typedef struct packed {
        spd_t speed_x;
        spd_t speed_y;
        spd_t speed_z;
        spd_t smooth_x;
        spd_t smooth_y;
        spd_t smooth_z;
    } result_t;

endpackage

// ----- hw/rtl/velocity_difference_smoother.sv -----
// Velocity difference smoother: per axis speed rate*(p[i]-p[i-k])/k, saturated to 32 bits
// and zero for the first k samples, plus its mean over the last avg_points speeds, zero for
// the first avg_points-1 samples. One sample word is taken at a time; sample_stall stays high
// while it is worked on. The processing time of an item is set by the shared divider, which
// delivers four quotient bits a cycle for three speed and three mean divisions, and by the
// speed history ram, read one row a cycle for the sum.
// A finished result word waits in an output register, so the next sample can be taken meanwhile.
// Histories reset to zero through per-row valid bits; no clearing pass is needed.
module velocity_difference_smoother
    import vds_pkg::*;
#(
    parameter int MAX_INTERVAL = 16,
    parameter int MAX_AVG      = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  sample_valid,
    output logic                  sample_stall,
    input  sample_t               sample,
    output logic                  result_valid,
    input  logic                  result_stall,
    output result_t               result,
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    localparam int PW      = (MAX_INTERVAL > 1) ? $clog2(MAX_INTERVAL) : 1;
    localparam int SW      = (MAX_AVG > 1) ? $clog2(MAX_AVG) : 1;
    localparam int CNT_MAX = MAX_INTERVAL + MAX_AVG - 1;
    localparam int CW      = $clog2(CNT_MAX + 1);
    localparam int SUM_W   = 33 + $clog2(MAX_AVG + 1);
    localparam int RW      = $clog2(2 * MAX_INTERVAL + 2 * MAX_AVG) + 1;
    localparam int PROW_W  = 3 * POS_W;
    localparam int SROW_W  = 3 * SPD_W;

    localparam logic [3:0] ST_IDLE  = 4'd0;
    localparam logic [3:0] ST_MUL   = 4'd1;
    localparam logic [3:0] ST_SDIV  = 4'd2;
    localparam logic [3:0] ST_SWAIT = 4'd3;
    localparam logic [3:0] ST_WR    = 4'd4;
    localparam logic [3:0] ST_SUM   = 4'd5;
    localparam logic [3:0] ST_ADIV  = 4'd6;
    localparam logic [3:0] ST_AWAIT = 4'd7;
    localparam logic [3:0] ST_DONE  = 4'd8;

    localparam logic [1:0] AXIS_X    = 2'd0;
    localparam logic [1:0] AXIS_Y    = 2'd1;
    localparam logic [1:0] AXIS_LAST = 2'd2;

    // configuration registers
    logic [RATE_W-1:0] rate_reg;
    logic [CFG_W-1:0]  interval_reg;
    logic [CFG_W-1:0]  avg_reg;

    // sequencer
    logic [3:0]       state_reg;
    logic [3:0]       state_next;
    logic [1:0]       axis_reg;
    logic [PW-1:0]    pos_wp_reg;
    logic [SW-1:0]    spd_wp_reg;
    logic [CW-1:0]    count_reg;
    logic [CFG_W-1:0] j_reg;
    logic             pend_reg;
    logic [MAX_INTERVAL-1:0] pos_vld_reg;
    logic [MAX_AVG-1:0]      spd_vld_reg;
    logic             pvld_q_reg;
    logic             svld_q_reg;
    logic             result_valid_reg;

    // payload
    sample_t                  samp_reg;
    logic signed [PROD_W-1:0] prod_reg;
    spd_t                     speed_reg [3];
    spd_t                     smooth_reg [3];
    logic signed [SUM_W-1:0]  acc_reg [3];
    result_t                  out_reg;

    // datapath wires
    logic [CFG_W-1:0]         k_eff;
    logic [CFG_W-1:0]         n_eff;
    logic [RW-1:0]            pos_ring;
    logic [RW-1:0]            spd_ring;
    logic [PW-1:0]            pos_raddr;
    logic [SW-1:0]            spd_raddr;
    logic                     sample_accept;
    logic                     pos_re;
    logic                     spd_re;
    logic                     row_we;
    logic [PROW_W-1:0]        pos_rdata;
    logic [SROW_W-1:0]        spd_rdata;
    logic [PROW_W-1:0]        old_row;
    logic [SROW_W-1:0]        spd_row;
    pos_t                     p_sel;
    pos_t                     o_sel;
    logic signed [DIFF_W-1:0] diff;
    logic signed [PROD_W:0]   prod_full;
    logic                     div_start;
    logic                     div_done;
    logic signed [SUM_W-1:0]  div_dvd;
    logic [CFG_W-1:0]         div_dvr;
    logic signed [SUM_W-1:0]  div_quo;
    logic [SUM_W-32:0]        quo_hi;
    spd_t                     quo_sat;
    logic                     speed_warm;
    logic                     smooth_warm;
    logic                     load_out;

    assign cfg_ready = 1'b1;

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rate_reg     <= RATE_RST;
            interval_reg <= INTERVAL_RST;
            avg_reg      <= AVG_RST;
        end
        else if (cfg_valid)
        begin
            unique case (cfg_index)
                CFG_RATE:     rate_reg     <= cfg_data;
                CFG_INTERVAL: interval_reg <= cfg_data[CFG_W-1:0];
                CFG_AVG:      avg_reg      <= cfg_data[CFG_W-1:0];
                default:      ;
            endcase
        end
    end

    // clamp interval and average length to their usable range
    always_comb
    begin
        if (interval_reg == '0)
        begin
            k_eff = CFG_W'(1);
        end
        else if (int'(interval_reg) > MAX_INTERVAL)
        begin
            k_eff = CFG_W'(MAX_INTERVAL);
        end
        else
        begin
            k_eff = interval_reg;
        end

        if (avg_reg == '0)
        begin
            n_eff = CFG_W'(1);
        end
        else if (int'(avg_reg) > MAX_AVG)
        begin
            n_eff = CFG_W'(MAX_AVG);
        end
        else
        begin
            n_eff = avg_reg;
        end
    end

    // ring addresses: position k back, speed j back
    always_comb
    begin
        pos_ring = RW'(pos_wp_reg) + RW'(MAX_INTERVAL) - RW'(k_eff);
        if (pos_ring >= RW'(MAX_INTERVAL))
        begin
            pos_ring = pos_ring - RW'(MAX_INTERVAL);
        end
        spd_ring = RW'(spd_wp_reg) + RW'(MAX_AVG) - RW'(j_reg);
        if (spd_ring >= RW'(MAX_AVG))
        begin
            spd_ring = spd_ring - RW'(MAX_AVG);
        end
    end

    assign pos_raddr = pos_ring[PW-1:0];
    assign spd_raddr = spd_ring[SW-1:0];

    // handshake and strobes
    assign sample_stall  = (state_reg != ST_IDLE);
    assign sample_accept = sample_valid && !sample_stall;
    assign pos_re        = sample_accept;
    assign spd_re        = (state_reg == ST_SUM) && (j_reg < n_eff);
    assign row_we        = (state_reg == ST_WR);
    assign div_start     = (state_reg == ST_SDIV) || (state_reg == ST_ADIV);
    assign load_out      = (state_reg == ST_DONE) && (!result_valid_reg || !result_stall);
    assign speed_warm    = int'(count_reg) < int'(k_eff);
    assign smooth_warm   = (int'(count_reg) + 1) < int'(n_eff);

    // history memories, one row holds all three axes
    vds_ram
    #(
        .WIDTH (PROW_W),
        .DEPTH (MAX_INTERVAL)
    )
    u_pos_ram
    (
        .clk   (clk),
        .we    (row_we),
        .waddr (pos_wp_reg),
        .wdata ({samp_reg.pos_z, samp_reg.pos_y, samp_reg.pos_x}),
        .re    (pos_re),
        .raddr (pos_raddr),
        .rdata (pos_rdata)
    );

    vds_ram
    #(
        .WIDTH (SROW_W),
        .DEPTH (MAX_AVG)
    )
    u_spd_ram
    (
        .clk   (clk),
        .we    (row_we),
        .waddr (spd_wp_reg),
        .wdata ({speed_reg[2], speed_reg[1], speed_reg[0]}),
        .re    (spd_re),
        .raddr (spd_raddr),
        .rdata (spd_rdata)
    );

    // rows never written read as zero
    assign old_row = pvld_q_reg ? pos_rdata : '0;
    assign spd_row = svld_q_reg ? spd_rdata : '0;

    // axis select, difference and rate product
    always_comb
    begin
        case (axis_reg)
            AXIS_X:
            begin
                p_sel = samp_reg.pos_x;
                o_sel = $signed(old_row[POS_W-1:0]);
            end
            AXIS_Y:
            begin
                p_sel = samp_reg.pos_y;
                o_sel = $signed(old_row[2*POS_W-1:POS_W]);
            end
            default:
            begin
                p_sel = samp_reg.pos_z;
                o_sel = $signed(old_row[3*POS_W-1:2*POS_W]);
            end
        endcase
        diff      = $signed({p_sel[POS_W-1], p_sel}) - $signed({o_sel[POS_W-1], o_sel});
        prod_full = $signed({1'b0, rate_reg}) * diff;
    end

    // shared divider operands
    always_comb
    begin
        if (state_reg == ST_SDIV)
        begin
            div_dvd = {{(SUM_W-PROD_W){prod_reg[PROD_W-1]}}, prod_reg};
            div_dvr = k_eff;
        end
        else
        begin
            div_dvd = acc_reg[axis_reg];
            div_dvr = n_eff;
        end
    end

    vds_div
    #(
        .DVD_W (SUM_W)
    )
    u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dvd),
        .divisor  (div_dvr),
        .done     (div_done),
        .quotient (div_quo)
    );

    // saturate the quotient to 32 bits
    always_comb
    begin
        quo_hi = div_quo[SUM_W-1:31];
        if ((&quo_hi) || !(|quo_hi))
        begin
            quo_sat = div_quo[31:0];
        end
        else if (div_quo[SUM_W-1])
        begin
            quo_sat = 32'sh8000_0000;
        end
        else
        begin
            quo_sat = 32'sh7fff_ffff;
        end
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_accept)
                begin
                    state_next = ST_MUL;
                end
            end
            ST_MUL:   state_next = ST_SDIV;
            ST_SDIV:  state_next = ST_SWAIT;
            ST_SWAIT:
            begin
                if (div_done)
                begin
                    state_next = (axis_reg == AXIS_LAST) ? ST_WR : ST_MUL;
                end
            end
            ST_WR:    state_next = ST_SUM;
            ST_SUM:
            begin
                if (!spd_re && !pend_reg)
                begin
                    state_next = ST_ADIV;
                end
            end
            ST_ADIV:  state_next = ST_AWAIT;
            ST_AWAIT:
            begin
                if (div_done)
                begin
                    state_next = (axis_reg == AXIS_LAST) ? ST_DONE : ST_ADIV;
                end
            end
            ST_DONE:
            begin
                if (load_out)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:  state_next = ST_IDLE;
        endcase
    end

    // sequencer control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            axis_reg         <= AXIS_X;
            pos_wp_reg       <= '0;
            spd_wp_reg       <= '0;
            count_reg        <= '0;
            j_reg            <= '0;
            pend_reg         <= 1'b0;
            pos_vld_reg      <= '0;
            spd_vld_reg      <= '0;
            pvld_q_reg       <= 1'b0;
            svld_q_reg       <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;

            // axis counter
            if (sample_accept || (state_reg == ST_WR))
            begin
                axis_reg <= AXIS_X;
            end
            else if (div_done && (axis_reg != AXIS_LAST))
            begin
                axis_reg <= axis_reg + 2'd1;
            end
            else if (div_done)
            begin
                axis_reg <= AXIS_X;
            end

            // valid bits follow the ram reads
            if (pos_re)
            begin
                pvld_q_reg <= pos_vld_reg[pos_raddr];
            end
            if (spd_re)
            begin
                svld_q_reg <= spd_vld_reg[spd_raddr];
            end
            if (row_we)
            begin
                pos_vld_reg[pos_wp_reg] <= 1'b1;
                spd_vld_reg[spd_wp_reg] <= 1'b1;
            end

            // sum walk over the speed history
            if (row_we)
            begin
                j_reg    <= '0;
                pend_reg <= 1'b0;
            end
            else if (state_reg == ST_SUM)
            begin
                pend_reg <= spd_re;
                if (spd_re)
                begin
                    j_reg <= j_reg + CFG_W'(1);
                end
            end

            // advance rings and sample count when the result is handed over
            if (load_out)
            begin
                pos_wp_reg <= (int'(pos_wp_reg) == MAX_INTERVAL - 1) ? '0 :
                              pos_wp_reg + PW'(1);
                spd_wp_reg <= (int'(spd_wp_reg) == MAX_AVG - 1) ? '0 :
                              spd_wp_reg + SW'(1);
                if (int'(count_reg) < CNT_MAX)
                begin
                    count_reg <= count_reg + CW'(1);
                end
            end

            // output word register
            if (load_out)
            begin
                result_valid_reg <= 1'b1;
            end
            else if (!result_stall)
            begin
                result_valid_reg <= 1'b0;
            end
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (sample_accept)
        begin
            samp_reg <= sample;
        end
        if (state_reg == ST_MUL)
        begin
            prod_reg <= prod_full[PROD_W-1:0];
        end
        if ((state_reg == ST_SWAIT) && div_done)
        begin
            speed_reg[axis_reg] <= speed_warm ? '0 : quo_sat;
        end
        if ((state_reg == ST_AWAIT) && div_done)
        begin
            smooth_reg[axis_reg] <= smooth_warm ? '0 : quo_sat;
        end

        // accumulate one speed row per cycle, all three axes
        if (row_we)
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc_reg[a] <= '0;
            end
        end
        else if ((state_reg == ST_SUM) && pend_reg)
        begin
            for (int a = 0; a < 3; a++)
            begin
                acc_reg[a] <= acc_reg[a] +
                    {{(SUM_W-SPD_W){spd_row[SPD_W*a+SPD_W-1]}}, spd_row[SPD_W*a +: SPD_W]};
            end
        end

        if (load_out)
        begin
            out_reg.speed_x  <= speed_reg[0];
            out_reg.speed_y  <= speed_reg[1];
            out_reg.speed_z  <= speed_reg[2];
            out_reg.smooth_x <= smooth_reg[0];
            out_reg.smooth_y <= smooth_reg[1];
            out_reg.smooth_z <= smooth_reg[2];
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = out_reg;

endmodule

// ----- hw/rtl/vds_ram.sv -----
// generic single write port ram with registered read
module vds_ram
#(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
)
(
    input  logic                                      clk,
    input  logic                                      we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                          wdata,
    input  logic                                      re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                          rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // write port
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
    end

    // registered read, holds when not reading
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- hw/rtl/vds_div.sv -----
// shared signed by unsigned divider, four quotient bits per cycle, truncates toward zero
module vds_div
    import vds_pkg::*;
#(
    parameter int DVD_W = 38
)
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [DVD_W-1:0] dividend,
    input  logic [CFG_W-1:0]        divisor,
    output logic                    done,
    output logic signed [DVD_W-1:0] quotient
);

    localparam int STEPS = (DVD_W + DIV_STEP - 1) / DIV_STEP;
    localparam int PAD_W = STEPS * DIV_STEP;
    localparam int SC_W  = $clog2(STEPS + 1);

    logic             busy_reg;
    logic             done_reg;
    logic [SC_W-1:0]  cnt_reg;
    logic             neg_reg;
    logic [PAD_W-1:0] sh_reg;
    logic [CFG_W-1:0] rem_reg;
    logic [CFG_W-1:0] dvr_reg;

    logic [DVD_W-1:0] mag;
    logic [PAD_W-1:0] sh_next;
    logic [CFG_W-1:0] rem_next;
    logic [CFG_W:0]   trial;
    logic signed [DVD_W-1:0] quo_mag;

    // magnitude of the dividend
    always_comb
    begin
        if (dividend[DVD_W-1])
        begin
            mag = DVD_W'(-dividend);
        end
        else
        begin
            mag = DVD_W'(dividend);
        end
    end

    // four restoring steps on the narrow remainder
    always_comb
    begin
        sh_next  = sh_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < DIV_STEP; i++)
        begin
            trial   = {rem_next, sh_next[PAD_W-1]};
            sh_next = {sh_next[PAD_W-2:0], 1'b0};
            if (trial >= {1'b0, dvr_reg})
            begin
                trial      = trial - {1'b0, dvr_reg};
                sh_next[0] = 1'b1;
            end
            rem_next = trial[CFG_W-1:0];
        end
    end

    // control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            done_reg <= 1'b0;
            cnt_reg  <= SC_W'(STEPS);
        end
        else if (busy_reg)
        begin
            cnt_reg <= cnt_reg - SC_W'(1);
            if (cnt_reg == SC_W'(1))
            begin
                busy_reg <= 1'b0;
                done_reg <= 1'b1;
            end
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    // datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            sh_reg  <= PAD_W'(mag);
            rem_reg <= '0;
            dvr_reg <= divisor;
            neg_reg <= dividend[DVD_W-1];
        end
        else if (busy_reg)
        begin
            sh_reg  <= sh_next;
            rem_reg <= rem_next;
        end
    end

    // restore the sign
    assign quo_mag  = $signed(sh_reg[DVD_W-1:0]);
    assign quotient = neg_reg ? -quo_mag : quo_mag;
    assign done     = done_reg;

endmodule

// ----- dv/tb_velocity_difference_smoother.sv -----
// self-checking testbench of the velocity difference smoother
module tb_velocity_difference_smoother;
    import vds_pkg::*;

    localparam int MAX_INTERVAL = 16;
    localparam int MAX_AVG      = 16;
    localparam int COUNT_TOP    = MAX_INTERVAL + MAX_AVG - 1;
    localparam int TOTAL_ITEMS  = 1350;
    localparam int SETTLE       = 200;
    localparam int LONG_HOLD    = 400;
    localparam int CYCLE_LIMIT  = 4000000;
    localparam longint SPD_MAX  = 64'sd2147483647;
    localparam longint SPD_MIN  = -64'sd2147483648;
    localparam pos_t POS_MAX    = 24'sh7fffff;
    localparam pos_t POS_MIN    = 24'sh800000;

    // index with no register behind it
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE = 2'd3;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  sample_valid = 1'b0;
    logic                  sample_stall;
    sample_t               sample = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    result_t               result;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DATA_W-1:0] cfg_data = '0;

    velocity_difference_smoother #(
        .MAX_INTERVAL(MAX_INTERVAL),
        .MAX_AVG(MAX_AVG)
    ) dut (
        .clk(clk),
        .rst_n(rst_n),
        .sample_valid(sample_valid),
        .sample_stall(sample_stall),
        .sample(sample),
        .result_valid(result_valid),
        .result_stall(result_stall),
        .result(result),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data(cfg_data)
    );

    // register copies seen by the predictor
    int rate_val = RATE_RST;
    int interval_val = INTERVAL_RST;
    int avg_val = AVG_RST;

    // history copies seen by the predictor
    pos_t pos_ring [3][MAX_INTERVAL];
    spd_t speed_ring [3][MAX_AVG];
    int pos_wr = 0;
    int speed_wr = 0;
    int seen_count = 0;

    sample_t queued_positions [$];
    result_t expected_speeds [$];

    int queued_count = 0;
    int checked_count = 0;
    int mismatch_count = 0;
    int clipped_count = 0;
    int settings_count = 0;
    int unsigned cycle_count = 0;

    // sender pacing
    int burst_left = 0;
    int gap_left = 0;

    // receiver pacing
    int hold_left = 0;
    int mode_left = 0;
    int stall_mode = 0;
    int run_left = 0;
    logic run_stall = 1'b0;
    int delivered_count = 0;

    // trajectory generator
    pos_t walk_pos [3];
    int walk_bits = 4;

    string field_names [6] = '{"speed_x", "speed_y", "speed_z",
                               "smooth_x", "smooth_y", "smooth_z"};

    initial
    begin
        foreach (pos_ring[a, i])
            pos_ring[a][i] = '0;
        foreach (speed_ring[a, i])
            speed_ring[a][i] = '0;
        foreach (walk_pos[a])
            walk_pos[a] = '0;
    end

    initial
    begin
        forever
            #1 clk = ~clk;
    end

    function automatic spd_t clip_speed(longint v);
        if (v > SPD_MAX)
            return spd_t'(SPD_MAX);
        if (v < SPD_MIN)
            return spd_t'(SPD_MIN);
        return spd_t'(v);
    endfunction

    // speeds and means of one position word, advancing the histories
    function automatic result_t predict_speeds(sample_t s);
        int k;
        int n;
        int back;
        longint pos [3];
        longint acc;
        spd_t spd [3];
        spd_t smo [3];
        result_t r;
        k = (interval_val < 1) ? 1 : (interval_val > MAX_INTERVAL) ? MAX_INTERVAL : interval_val;
        n = (avg_val < 1) ? 1 : (avg_val > MAX_AVG) ? MAX_AVG : avg_val;
        pos[0] = s.pos_x;
        pos[1] = s.pos_y;
        pos[2] = s.pos_z;
        back = (pos_wr + MAX_INTERVAL - k) % MAX_INTERVAL;
        // finite difference, zero until k samples are in
        for (int a = 0; a < 3; a++)
        begin
            if (seen_count < k)
                spd[a] = '0;
            else
            begin
                acc = (longint'(rate_val) * (pos[a] - longint'(pos_ring[a][back]))) / k;
                if (acc > SPD_MAX || acc < SPD_MIN)
                    clipped_count++;
                spd[a] = clip_speed(acc);
            end
            pos_ring[a][pos_wr] = pos_t'(pos[a]);
            speed_ring[a][speed_wr] = spd[a];
        end
        // mean of the newest n speeds
        for (int a = 0; a < 3; a++)
        begin
            acc = 0;
            for (int j = 0; j < n; j++)
                acc += speed_ring[a][(speed_wr + MAX_AVG - j) % MAX_AVG];
            smo[a] = (seen_count + 1 < n) ? spd_t'(0) : clip_speed(acc / n);
        end
        pos_wr = (pos_wr + 1) % MAX_INTERVAL;
        speed_wr = (speed_wr + 1) % MAX_AVG;
        if (seen_count < COUNT_TOP)
            seen_count++;
        r.speed_x = spd[0];
        r.speed_y = spd[1];
        r.speed_z = spd[2];
        r.smooth_x = smo[0];
        r.smooth_y = smo[1];
        r.smooth_z = smo[2];
        return r;
    endfunction

    task automatic report_mismatch(string msg);
        if (mismatch_count < 30)
            $display("mismatch: %s", msg);
        mismatch_count++;
    endtask

    function automatic void add_sample(sample_t s);
        queued_positions.push_back(s);
        queued_count++;
    endfunction

    // mostly smooth trajectories, some noise and corner values
    function automatic sample_t next_position();
        int pick;
        int span;
        pos_t corner [3];
        pick = $urandom_range(0, 19);
        span = 1 << walk_bits;
        if (pick < 15)
        begin
            for (int a = 0; a < 3; a++)
                walk_pos[a] = walk_pos[a] + pos_t'(int'($urandom_range(0, span)) - span / 2);
            return sample_t'{walk_pos[0], walk_pos[1], walk_pos[2]};
        end
        if (pick < 18)
            return sample_t'{pos_t'(24'($urandom())), pos_t'(24'($urandom())),
                             pos_t'(24'($urandom()))};
        for (int a = 0; a < 3; a++)
        begin
            case ($urandom_range(0, 3))
                0: corner[a] = POS_MAX;
                1: corner[a] = POS_MIN;
                2: corner[a] = '0;
                default: corner[a] = '1;
            endcase
        end
        return sample_t'{corner[0], corner[1], corner[2]};
    endfunction

    // wait until the block has returned every word and gone quiet
    task automatic drain();
        do
        begin
            @(negedge clk);
        end
        while (queued_positions.size() != 0 || sample_valid || expected_speeds.size() != 0);
        repeat (SETTLE) @(negedge clk);
    endtask

    task automatic write_register(logic [CFG_IDX_W-1:0] index, logic [CFG_DATA_W-1:0] data);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= index;
        cfg_data <= data;
        do
        begin
            @(posedge clk);
        end
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (index)
            CFG_RATE: rate_val = data;
            CFG_INTERVAL: interval_val = data[CFG_W-1:0];
            CFG_AVG: avg_val = data[CFG_W-1:0];
            default: ;
        endcase
    endtask

    task automatic apply_settings(logic [7:0] rate, logic [7:0] interval, logic [7:0] avg);
        drain();
        write_register(CFG_RATE, rate);
        write_register(CFG_INTERVAL, interval);
        write_register(CFG_AVG, avg);
        settings_count++;
        @(negedge clk);
    endtask

    // position word driver, bursts with random gaps
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            sample_valid <= 1'b0;
            sample <= '0;
        end
        else
        begin
            if (sample_valid && !sample_stall)
                expected_speeds.push_back(predict_speeds(queued_positions.pop_front()));
            // a stalled word stays put
            if (!(sample_valid && sample_stall))
            begin
                if (gap_left > 0)
                begin
                    gap_left--;
                    sample_valid <= 1'b0;
                end
                else if (queued_positions.size() == 0)
                    sample_valid <= 1'b0;
                else
                begin
                    sample_valid <= 1'b1;
                    sample <= queued_positions[0];
                    if (burst_left > 1)
                        burst_left--;
                    else
                    begin
                        burst_left = $urandom_range(1, 8);
                        gap_left = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 150);
                    end
                end
            end
        end
    end

    // result stall pattern, with two long hold-offs
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (hold_left > 0)
            begin
                hold_left--;
                result_stall <= 1'b1;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 300);
                end
                mode_left--;
                case (stall_mode)
                    0: result_stall <= 1'b0;
                    1: result_stall <= ($urandom_range(0, 3) == 0);
                    2: result_stall <= ($urandom_range(0, 3) != 0);
                    default:
                    begin
                        if (run_left == 0)
                        begin
                            run_stall = !run_stall;
                            run_left = $urandom_range(1, 120);
                        end
                        run_left--;
                        result_stall <= run_stall;
                    end
                endcase
            end
            if (result_valid && !result_stall)
            begin
                delivered_count++;
                if (delivered_count == 250 || delivered_count == 800)
                    hold_left = LONG_HOLD;
            end
        end
    end

    // result word checker
    always @(posedge clk)
    begin : result_monitor
        result_t want;
        spd_t got_f [6];
        spd_t want_f [6];
        if (rst_n && result_valid && !result_stall)
        begin
            if (expected_speeds.size() == 0)
                report_mismatch("result word with nothing expected");
            else
            begin
                want = expected_speeds.pop_front();
                got_f = '{result.speed_x, result.speed_y, result.speed_z,
                          result.smooth_x, result.smooth_y, result.smooth_z};
                want_f = '{want.speed_x, want.speed_y, want.speed_z,
                           want.smooth_x, want.smooth_y, want.smooth_z};
                for (int f = 0; f < 6; f++)
                begin
                    if (got_f[f] !== want_f[f])
                        report_mismatch($sformatf("word %0d %s: got %0d, want %0d",
                                                  checked_count, field_names[f],
                                                  got_f[f], want_f[f]));
                end
                checked_count++;
            end
        end
    end

    // watchdog
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("status: fail");
            $finish;
        end
    end

    // stimulus sequence
    initial
    begin : stimulus
        int segment;
        int batch;
        logic [7:0] rate;
        logic [7:0] interval;
        logic [7:0] avg;
        segment = 0;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // reset settings, extremes and bit patterns
        add_sample(sample_t'{24'sd0, 24'sd0, 24'sd0});
        add_sample(sample_t'{POS_MAX, POS_MIN, 24'sd1});
        add_sample(sample_t'{POS_MIN, POS_MAX, -24'sd1});
        add_sample(sample_t'{24'sh555555, 24'shaaaaaa, 24'sd256});
        add_sample(sample_t'{24'shaaaaaa, 24'sh555555, -24'sd256});
        add_sample(sample_t'{24'sd3, -24'sd7, 24'sd100});

        // high rate, unit interval and window: speeds clip both ways
        apply_settings(8'd240, 8'd1, 8'd1);
        add_sample(sample_t'{POS_MAX, POS_MIN, POS_MAX});
        add_sample(sample_t'{POS_MIN, POS_MAX, POS_MIN});
        add_sample(sample_t'{POS_MAX, POS_MIN, POS_MAX});
        add_sample(sample_t'{24'sd0, 24'sd0, 24'sd0});

        // zero rate, zero interval and window, masked upper bits, spare index
        apply_settings(8'd0, 8'he0, 8'h00);
        write_register(CFG_SPARE, 8'($urandom()));
        @(negedge clk);
        repeat (3) add_sample(next_position());

        // largest rate, interval and window beyond the histories
        apply_settings(8'd255, 8'hff, 8'hff);
        walk_bits = 12;
        repeat (10) add_sample(next_position());

        // random settings and trajectories
        while (queued_count < TOTAL_ITEMS)
        begin
            case ($urandom_range(0, 9))
                0: rate = 8'd0;
                1: rate = 8'd255;
                2: rate = 8'd240;
                3: rate = 8'd1;
                default: rate = $urandom_range(1, 240);
            endcase
            case ($urandom_range(0, 9))
                0: interval = 8'd0;
                1: interval = $urandom_range(17, 31);
                2: interval = 8'd16;
                3: interval = 8'd1;
                default: interval = $urandom_range(1, 16);
            endcase
            case ($urandom_range(0, 9))
                0: avg = 8'd0;
                1: avg = $urandom_range(17, 31);
                2: avg = 8'd16;
                3: avg = 8'd1;
                default: avg = $urandom_range(1, 16);
            endcase
            interval[7:5] = 3'($urandom());
            avg[7:5] = 3'($urandom());
            apply_settings(rate, interval, avg);
            walk_bits = $urandom_range(0, 20);
            batch = $urandom_range(30, 90);
            for (int i = 0; i < batch; i++)
            begin
                // sender pause until every word is back
                if (segment == 3 && i == batch / 2)
                    drain();
                add_sample(next_position());
            end
            segment++;
        end

        drain();
        $display("checked %0d result words over %0d register settings, %0d speeds clipped",
                 checked_count, settings_count, clipped_count);
        $display("receiver held off %0d cycles twice, %0d mismatches", LONG_HOLD,
                 mismatch_count);
        if (mismatch_count == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule

// ----- files.f -----
hw/rtl/vds_pkg.sv
hw/rtl/vds_ram.sv
hw/rtl/vds_div.sv
hw/rtl/velocity_difference_smoother.sv
dv/tb_velocity_difference_smoother.sv
